/* hw/rtl/les_pkg.sv */
`default_nettype none

package les_pkg;

    localparam int COORD_W   = 32;
    localparam int DT_W      = 22;
    localparam int IDX_W     = 24;
    localparam int CFG_IDX_W = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGMA  = 4'd0,
        CFG_RHO    = 4'd1,
        CFG_BETA   = 4'd2,
        CFG_DT     = 4'd3,
        CFG_INIT_X = 4'd4,
        CFG_INIT_Y = 4'd5,
        CFG_INIT_Z = 4'd6,
        CFG_LIMIT  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic advance;
        logic restart;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [IDX_W-1:0]          step_index;
        logic                      limit_reached;
        logic                      saturated;
    } t_out_item;

    // operand sources for the shared unit
    typedef enum logic [3:0] {
        OPN_ZERO  = 4'd0,
        OPN_X     = 4'd1,
        OPN_Y     = 4'd2,
        OPN_Z     = 4'd3,
        OPN_SIGMA = 4'd4,
        OPN_RHO   = 4'd5,
        OPN_BETA  = 4'd6,
        OPN_DT    = 4'd7,
        OPN_D1    = 4'd8,
        OPN_D2    = 4'd9,
        OPN_RX    = 4'd10,
        OPN_RY    = 4'd11,
        OPN_RZ    = 4'd12,
        OPN_A     = 4'd13
    } t_opnd;

    // result destinations
    typedef enum logic [3:0] {
        DST_D1 = 4'd0,
        DST_D2 = 4'd1,
        DST_RX = 4'd2,
        DST_RY = 4'd3,
        DST_RZ = 4'd4,
        DST_A  = 4'd5,
        DST_NX = 4'd6,
        DST_NY = 4'd7,
        DST_NZ = 4'd8
    } t_dest;

    // first adder input: register operand, saturated product, raw product
    typedef enum logic [1:0] {
        SRC_REG  = 2'd0,
        SRC_PSAT = 2'd1,
        SRC_PRAW = 2'd2
    } t_src;

    // adder operation on (s, c)
    typedef enum logic [1:0] {
        AOP_PASS = 2'd0,
        AOP_ADD  = 2'd1,
        AOP_SUB  = 2'd2,
        AOP_RSUB = 2'd3
    } t_aop;

    typedef struct packed {
        logic  mul_en;
        t_opnd mul_a;
        t_opnd mul_b;
        logic  alu_en;
        t_src  src;
        t_aop  aop;
        t_opnd alu_s;
        t_opnd alu_c;
        t_dest dest;
    } t_ctl;

    typedef struct packed {
        logic idle;
        logic commit;
        logic push;
    } t_seq_stat;

endpackage

`default_nettype wire

/* hw/rtl/les_alu.sv */
`default_nettype none

module les_alu #(
    parameter int FRAC_BITS = 22
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_mul_en,
    input  wire logic signed [les_pkg::COORD_W-1:0]   i_mul_a,
    input  wire logic signed [les_pkg::COORD_W-1:0]   i_mul_b,
    input  wire logic                                 i_alu_en,
    input  wire les_pkg::t_src                        i_src,
    input  wire les_pkg::t_aop                        i_aop,
    input  wire logic signed [les_pkg::COORD_W-1:0]   i_opnd_s,
    input  wire logic signed [les_pkg::COORD_W-1:0]   i_opnd_c,
    output logic signed [les_pkg::COORD_W-1:0]        o_res,
    output logic                                      o_clip
);

    localparam int PW = 2 * les_pkg::COORD_W;

    typedef struct packed {
        logic                              clip;
        logic signed [les_pkg::COORD_W-1:0] val;
    } t_sat;

    function automatic t_sat sat32(input logic signed [PW-1:0] v);
        t_sat r;
        r.clip = !((&v[PW-1:les_pkg::COORD_W-1]) || !(|v[PW-1:les_pkg::COORD_W-1]));
        if (r.clip) begin
            r.val = v[PW-1] ? {1'b1, {(les_pkg::COORD_W-1){1'b0}}}
                            : {1'b0, {(les_pkg::COORD_W-1){1'b1}}};
        end else begin
            r.val = v[les_pkg::COORD_W-1:0];
        end
        return r;
    endfunction

    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] scaled;
    t_sat                 pre;
    logic signed [PW-1:0] s_ext;
    logic signed [PW-1:0] c_ext;
    logic signed [PW-1:0] sum;
    t_sat                 post;

    assign mul_p = PW'(i_mul_a) * PW'(i_mul_b);

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= mul_p;
        end
    end

    // floor scaling of the registered product
    assign scaled = r_prod >>> FRAC_BITS;
    assign pre    = sat32(scaled);
    assign c_ext  = PW'(i_opnd_c);

    always_comb begin
        case (i_src)
            les_pkg::SRC_PSAT: s_ext = PW'(pre.val);
            les_pkg::SRC_PRAW: s_ext = scaled;
            default:           s_ext = PW'(i_opnd_s);
        endcase
        case (i_aop)
            les_pkg::AOP_ADD:  sum = s_ext + c_ext;
            les_pkg::AOP_SUB:  sum = s_ext - c_ext;
            les_pkg::AOP_RSUB: sum = c_ext - s_ext;
            default:           sum = s_ext;
        endcase
    end

    assign post   = sat32(sum);
    assign o_res  = post.val;
    assign o_clip = i_alu_en && (post.clip || ((i_src == les_pkg::SRC_PSAT) && pre.clip));

endmodule

`default_nettype wire

/* hw/rtl/les_seq.sv */
`default_nettype none

module les_seq (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic         i_step,
    input  wire logic         i_out_free,
    output les_pkg::t_ctl     o_ctl,
    output les_pkg::t_seq_stat o_stat
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_C1   = 12'b0000_0000_0010,
        S_C2   = 12'b0000_0000_0100,
        S_C3   = 12'b0000_0000_1000,
        S_C4   = 12'b0000_0001_0000,
        S_C5   = 12'b0000_0010_0000,
        S_C6   = 12'b0000_0100_0000,
        S_C7   = 12'b0000_1000_0000,
        S_C8   = 12'b0001_0000_0000,
        S_C9   = 12'b0010_0000_0000,
        S_C10  = 12'b0100_0000_0000,
        S_PUSH = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = i_step ? S_C1 : S_PUSH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_C1:   n_state = S_C2;
            S_C2:   n_state = S_C3;
            S_C3:   n_state = S_C4;
            S_C4:   n_state = S_C5;
            S_C5:   n_state = S_C6;
            S_C6:   n_state = S_C7;
            S_C7:   n_state = S_C8;
            S_C8:   n_state = S_C9;
            S_C9:   n_state = S_C10;
            S_C10:  n_state = S_PUSH;
            S_PUSH: n_state = i_out_free ? S_IDLE : S_PUSH;
            default: n_state = S_IDLE;
        endcase
    end

    // microcode: a product issued in one state is consumed by the adder in the next
    always_comb begin
        o_ctl.mul_en = 1'b0;
        o_ctl.mul_a  = les_pkg::OPN_ZERO;
        o_ctl.mul_b  = les_pkg::OPN_ZERO;
        o_ctl.alu_en = 1'b0;
        o_ctl.src    = les_pkg::SRC_REG;
        o_ctl.aop    = les_pkg::AOP_PASS;
        o_ctl.alu_s  = les_pkg::OPN_ZERO;
        o_ctl.alu_c  = les_pkg::OPN_ZERO;
        o_ctl.dest   = les_pkg::DST_D1;
        case (r_state)
            S_C1: begin
                o_ctl.alu_en = 1'b1;
                o_ctl.aop    = les_pkg::AOP_SUB;
                o_ctl.alu_s  = les_pkg::OPN_Y;
                o_ctl.alu_c  = les_pkg::OPN_X;
                o_ctl.dest   = les_pkg::DST_D1;
            end
            S_C2: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.mul_a  = les_pkg::OPN_SIGMA;
                o_ctl.mul_b  = les_pkg::OPN_D1;
                o_ctl.alu_en = 1'b1;
                o_ctl.aop    = les_pkg::AOP_SUB;
                o_ctl.alu_s  = les_pkg::OPN_RHO;
                o_ctl.alu_c  = les_pkg::OPN_Z;
                o_ctl.dest   = les_pkg::DST_D2;
            end
            S_C3: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.mul_a  = les_pkg::OPN_X;
                o_ctl.mul_b  = les_pkg::OPN_D2;
                o_ctl.alu_en = 1'b1;
                o_ctl.src    = les_pkg::SRC_PSAT;
                o_ctl.dest   = les_pkg::DST_RX;
            end
            S_C4: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.mul_a  = les_pkg::OPN_DT;
                o_ctl.mul_b  = les_pkg::OPN_RX;
                o_ctl.alu_en = 1'b1;
                o_ctl.src    = les_pkg::SRC_PSAT;
                o_ctl.aop    = les_pkg::AOP_SUB;
                o_ctl.alu_c  = les_pkg::OPN_Y;
                o_ctl.dest   = les_pkg::DST_RY;
            end
            S_C5: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.mul_a  = les_pkg::OPN_DT;
                o_ctl.mul_b  = les_pkg::OPN_RY;
                o_ctl.alu_en = 1'b1;
                o_ctl.src    = les_pkg::SRC_PRAW;
                o_ctl.aop    = les_pkg::AOP_ADD;
                o_ctl.alu_c  = les_pkg::OPN_X;
                o_ctl.dest   = les_pkg::DST_NX;
            end
            S_C6: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.mul_a  = les_pkg::OPN_X;
                o_ctl.mul_b  = les_pkg::OPN_Y;
                o_ctl.alu_en = 1'b1;
                o_ctl.src    = les_pkg::SRC_PRAW;
                o_ctl.aop    = les_pkg::AOP_ADD;
                o_ctl.alu_c  = les_pkg::OPN_Y;
                o_ctl.dest   = les_pkg::DST_NY;
            end
            S_C7: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.mul_a  = les_pkg::OPN_BETA;
                o_ctl.mul_b  = les_pkg::OPN_Z;
                o_ctl.alu_en = 1'b1;
                o_ctl.src    = les_pkg::SRC_PSAT;
                o_ctl.dest   = les_pkg::DST_A;
            end
            S_C8: begin
                o_ctl.alu_en = 1'b1;
                o_ctl.src    = les_pkg::SRC_PSAT;
                o_ctl.aop    = les_pkg::AOP_RSUB;
                o_ctl.alu_c  = les_pkg::OPN_A;
                o_ctl.dest   = les_pkg::DST_RZ;
            end
            S_C9: begin
                o_ctl.mul_en = 1'b1;
                o_ctl.mul_a  = les_pkg::OPN_DT;
                o_ctl.mul_b  = les_pkg::OPN_RZ;
            end
            S_C10: begin
                o_ctl.alu_en = 1'b1;
                o_ctl.src    = les_pkg::SRC_PRAW;
                o_ctl.aop    = les_pkg::AOP_ADD;
                o_ctl.alu_c  = les_pkg::OPN_Z;
                o_ctl.dest   = les_pkg::DST_NZ;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.idle   = (r_state == S_IDLE);
    assign o_stat.commit = (r_state == S_C10);
    assign o_stat.push   = (r_state == S_PUSH);

endmodule

`default_nettype wire

/* hw/rtl/lorenz_euler_step_core.sv */
// a stepping item runs through states C1 to C10 and then the push state, which waits
// for a free output register; a report-only item goes straight to push; a new item is
// taken only while idle, after the last one is pushed. Each step computes seven products
// through one shared 32x32 multiplier and one saturating adder over states C1 to C10
// reset: synchronous, active low; restores register defaults, point 10.0 and count one
`default_nettype none

module lorenz_euler_step_core #(
    parameter int FRAC_BITS   = 22,
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // item input
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire les_pkg::t_in_item                   i_in_data,
    // result output
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output les_pkg::t_out_item                       o_out_data,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [les_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [les_pkg::COORD_W-1:0]         i_cfg_data
);

    localparam int CW    = les_pkg::COORD_W;
    localparam int CMP_W = (COUNT_WIDTH > les_pkg::IDX_W) ? COUNT_WIDTH : les_pkg::IDX_W;

    // defaults in the chosen fixed point format, clipped to 32 bits
    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint S32_MAX  = 64'sd2147483647;
    localparam longint TEN_Q    = 10 * ONE;
    localparam longint RHO_Q    = 28 * ONE;
    localparam longint BETA_Q   = (8 * ONE + 1) / 3;
    localparam logic [CW-1:0] TEN_DEF  = (TEN_Q > S32_MAX) ? CW'(S32_MAX) : CW'(TEN_Q);
    localparam logic [CW-1:0] RHO_DEF  = (RHO_Q > S32_MAX) ? CW'(S32_MAX) : CW'(RHO_Q);
    localparam logic [CW-1:0] BETA_DEF = (BETA_Q > S32_MAX) ? CW'(S32_MAX) : CW'(BETA_Q);
    localparam logic [les_pkg::DT_W-1:0]  DT_DEF    = les_pkg::DT_W'(ONE / 100);
    localparam logic [les_pkg::IDX_W-1:0] LIMIT_DEF = les_pkg::IDX_W'(10000000);

    // configuration registers
    logic signed [CW-1:0]         r_sigma;
    logic signed [CW-1:0]         r_rho;
    logic signed [CW-1:0]         r_beta;
    logic [les_pkg::DT_W-1:0]     r_dt;
    logic signed [CW-1:0]         r_init_x;
    logic signed [CW-1:0]         r_init_y;
    logic signed [CW-1:0]         r_init_z;
    logic [les_pkg::IDX_W-1:0]    r_limit;

    // integrator state
    logic signed [CW-1:0]         r_pos_x;
    logic signed [CW-1:0]         r_pos_y;
    logic signed [CW-1:0]         r_pos_z;
    logic [COUNT_WIDTH-1:0]       r_cnt;
    logic                         r_clip;

    // intermediate terms of one step
    logic signed [CW-1:0]         r_d1;
    logic signed [CW-1:0]         r_d2;
    logic signed [CW-1:0]         r_rx;
    logic signed [CW-1:0]         r_ry;
    logic signed [CW-1:0]         r_rz;
    logic signed [CW-1:0]         r_a;
    logic signed [CW-1:0]         r_nx;
    logic signed [CW-1:0]         r_ny;

    // output register
    les_pkg::t_out_item           r_out;
    logic                         r_out_valid;

    les_pkg::t_ctl                ctl;
    les_pkg::t_seq_stat           stat;
    logic                         in_acc;
    logic                         out_free;
    logic                         step_ok;
    logic [COUNT_WIDTH-1:0]       cnt_eff;
    logic [CMP_W-1:0]             cnt_ext;
    logic [CMP_W-1:0]             limit_ext;
    logic signed [CW-1:0]         mul_a;
    logic signed [CW-1:0]         mul_b;
    logic signed [CW-1:0]         alu_s;
    logic signed [CW-1:0]         alu_c;
    logic signed [CW-1:0]         alu_res;
    logic                         alu_clip;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [CW-1:0] sigma;
        logic signed [CW-1:0] rho;
        logic signed [CW-1:0] beta;
        logic signed [CW-1:0] dt;
        logic signed [CW-1:0] d1;
        logic signed [CW-1:0] d2;
        logic signed [CW-1:0] rx;
        logic signed [CW-1:0] ry;
        logic signed [CW-1:0] rz;
        logic signed [CW-1:0] a;
    } t_bank;

    t_bank bank;

    function automatic logic signed [CW-1:0] pick(input les_pkg::t_opnd sel, input t_bank b);
        logic signed [CW-1:0] v;
        case (sel)
            les_pkg::OPN_X:     v = b.x;
            les_pkg::OPN_Y:     v = b.y;
            les_pkg::OPN_Z:     v = b.z;
            les_pkg::OPN_SIGMA: v = b.sigma;
            les_pkg::OPN_RHO:   v = b.rho;
            les_pkg::OPN_BETA:  v = b.beta;
            les_pkg::OPN_DT:    v = b.dt;
            les_pkg::OPN_D1:    v = b.d1;
            les_pkg::OPN_D2:    v = b.d2;
            les_pkg::OPN_RX:    v = b.rx;
            les_pkg::OPN_RY:    v = b.ry;
            les_pkg::OPN_RZ:    v = b.rz;
            les_pkg::OPN_A:     v = b.a;
            default:            v = '0;
        endcase
        return v;
    endfunction

    // handshakes: new items only while idle, output register frees when taken
    assign in_acc      = i_in_valid && stat.idle;
    assign o_in_stall  = !stat.idle;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // restart takes effect before the step decision
    assign cnt_eff   = i_in_data.restart ? COUNT_WIDTH'(1) : r_cnt;
    assign limit_ext = CMP_W'(r_limit);
    assign step_ok   = i_in_data.advance && (CMP_W'(cnt_eff) < limit_ext) && !(&cnt_eff);
    assign cnt_ext   = CMP_W'(r_cnt);

    // operand bank for the shared unit
    assign bank.x     = r_pos_x;
    assign bank.y     = r_pos_y;
    assign bank.z     = r_pos_z;
    assign bank.sigma = r_sigma;
    assign bank.rho   = r_rho;
    assign bank.beta  = r_beta;
    assign bank.dt    = CW'(r_dt);
    assign bank.d1    = r_d1;
    assign bank.d2    = r_d2;
    assign bank.rx    = r_rx;
    assign bank.ry    = r_ry;
    assign bank.rz    = r_rz;
    assign bank.a     = r_a;

    assign mul_a = pick(ctl.mul_a, bank);
    assign mul_b = pick(ctl.mul_b, bank);
    assign alu_s = pick(ctl.alu_s, bank);
    assign alu_c = pick(ctl.alu_c, bank);

    les_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_step     (step_ok),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_stat     (stat)
    );

    les_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_mul_en (ctl.mul_en),
        .i_mul_a  (mul_a),
        .i_mul_b  (mul_b),
        .i_alu_en (ctl.alu_en),
        .i_src    (ctl.src),
        .i_aop    (ctl.aop),
        .i_opnd_s (alu_s),
        .i_opnd_c (alu_c),
        .o_res    (alu_res),
        .o_clip   (alu_clip)
    );

    // configuration writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma  <= TEN_DEF;
            r_rho    <= RHO_DEF;
            r_beta   <= BETA_DEF;
            r_dt     <= DT_DEF;
            r_init_x <= TEN_DEF;
            r_init_y <= TEN_DEF;
            r_init_z <= TEN_DEF;
            r_limit  <= LIMIT_DEF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                les_pkg::CFG_SIGMA:  r_sigma  <= i_cfg_data;
                les_pkg::CFG_RHO:    r_rho    <= i_cfg_data;
                les_pkg::CFG_BETA:   r_beta   <= i_cfg_data;
                les_pkg::CFG_DT:     r_dt     <= i_cfg_data[les_pkg::DT_W-1:0];
                les_pkg::CFG_INIT_X: r_init_x <= i_cfg_data;
                les_pkg::CFG_INIT_Y: r_init_y <= i_cfg_data;
                les_pkg::CFG_INIT_Z: r_init_z <= i_cfg_data;
                les_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[les_pkg::IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // point and count: restart on acceptance, new point at the end of a step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= TEN_DEF;
            r_pos_y <= TEN_DEF;
            r_pos_z <= TEN_DEF;
            r_cnt   <= COUNT_WIDTH'(1);
        end else if (in_acc && i_in_data.restart) begin
            r_pos_x <= r_init_x;
            r_pos_y <= r_init_y;
            r_pos_z <= r_init_z;
            r_cnt   <= COUNT_WIDTH'(1);
        end else if (stat.commit) begin
            r_pos_x <= r_nx;
            r_pos_y <= r_ny;
            r_pos_z <= alu_res;
            r_cnt   <= r_cnt + COUNT_WIDTH'(1);
        end
    end

    // clip flag gathers every saturation of the current item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= 1'b0;
        end else if (in_acc) begin
            r_clip <= 1'b0;
        end else if (alu_clip) begin
            r_clip <= 1'b1;
        end
    end

    // intermediate terms, written by the shared unit
    always_ff @(posedge i_clk) begin
        if (ctl.alu_en) begin
            case (ctl.dest)
                les_pkg::DST_D1: r_d1 <= alu_res;
                les_pkg::DST_D2: r_d2 <= alu_res;
                les_pkg::DST_RX: r_rx <= alu_res;
                les_pkg::DST_RY: r_ry <= alu_res;
                les_pkg::DST_RZ: r_rz <= alu_res;
                les_pkg::DST_A:  r_a  <= alu_res;
                les_pkg::DST_NX: r_nx <= alu_res;
                les_pkg::DST_NY: r_ny <= alu_res;
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.push && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.push && out_free) begin
            r_out.out_x         <= r_pos_x;
            r_out.out_y         <= r_pos_y;
            r_out.out_z         <= r_pos_z;
            r_out.step_index    <= cnt_ext[les_pkg::IDX_W-1:0];
            r_out.limit_reached <= (cnt_ext >= limit_ext);
            r_out.saturated     <= r_clip;
        end
    end

endmodule

`default_nettype wire

/* verif/les_checker.sv */
module les_checker
    import les_pkg::*;
#(
    parameter int FRAC_BITS   = 22,
    parameter int COUNT_WIDTH = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire t_in_item             i_in_data,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire t_out_item            i_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COORD_W-1:0]   i_cfg_data,
    output int                        o_errors,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint S32_MAX     = 64'sh7FFF_FFFF;
    localparam longint S32_MIN     = -64'sh8000_0000;
    localparam longint UNIT        = longint'(1) << FRAC_BITS;
    localparam longint COUNT_TOP   = (longint'(1) << COUNT_WIDTH) - 1;
    localparam int     MAX_REPORTS = 10;

    // register copies
    longint prm_sigma, prm_rho, prm_beta, prm_dt;
    longint start_x, start_y, start_z, stop_count;
    // trajectory
    longint cur_x, cur_y, cur_z, cur_count;
    bit     clipped;

    t_out_item points_due[$];
    int        err_count = 0;
    int        result_no = 0;

    function automatic longint clamp32(input longint v);
        if (v > S32_MAX) begin
            clipped = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            clipped = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // exact product, scaled down with rounding toward minus infinity
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic void load_defaults();
        prm_sigma  = 10 * UNIT;
        prm_rho    = 28 * UNIT;
        prm_beta   = (8 * UNIT + 1) / 3;
        prm_dt     = UNIT / 100;
        start_x    = 10 * UNIT;
        start_y    = 10 * UNIT;
        start_z    = 10 * UNIT;
        stop_count = 10000000;
        cur_x      = 10 * UNIT;
        cur_y      = 10 * UNIT;
        cur_z      = 10 * UNIT;
        cur_count  = 1;
    endfunction

    function automatic void write_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [COORD_W-1:0] data);
        case (idx)
            CFG_SIGMA:  prm_sigma  = longint'($signed(data));
            CFG_RHO:    prm_rho    = longint'($signed(data));
            CFG_BETA:   prm_beta   = longint'($signed(data));
            CFG_DT:     prm_dt     = longint'(data[DT_W-1:0]);
            CFG_INIT_X: start_x    = longint'($signed(data));
            CFG_INIT_Y: start_y    = longint'($signed(data));
            CFG_INIT_Z: start_z    = longint'($signed(data));
            CFG_LIMIT:  stop_count = longint'(data[IDX_W-1:0]);
            default: ;
        endcase
    endfunction

    // restart if asked, then one lorenz euler step if allowed, rates from the previous point
    function automatic t_out_item next_point(input t_in_item it);
        t_out_item r;
        longint    rx, ry, rz, nx, ny, nz;
        clipped = 1'b0;
        if (it.restart) begin
            cur_x     = start_x;
            cur_y     = start_y;
            cur_z     = start_z;
            cur_count = 1;
        end
        if (it.advance && cur_count < stop_count && cur_count < COUNT_TOP) begin
            rx = clamp32(qmul(prm_sigma, clamp32(cur_y - cur_x)));
            ry = clamp32(clamp32(qmul(cur_x, clamp32(prm_rho - cur_z))) - cur_y);
            rz = clamp32(clamp32(qmul(cur_x, cur_y)) - clamp32(qmul(prm_beta, cur_z)));
            nx = clamp32(cur_x + qmul(prm_dt, rx));
            ny = clamp32(cur_y + qmul(prm_dt, ry));
            nz = clamp32(cur_z + qmul(prm_dt, rz));
            cur_x = nx;
            cur_y = ny;
            cur_z = nz;
            cur_count++;
        end
        r.out_x         = cur_x[COORD_W-1:0];
        r.out_y         = cur_y[COORD_W-1:0];
        r.out_z         = cur_z[COORD_W-1:0];
        r.step_index    = cur_count[IDX_W-1:0];
        r.limit_reached = (cur_count >= stop_count);
        r.saturated     = clipped;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("[%0t] result %0d, %s: expected %h, got %h",
                         $time, result_no, name, want, got);
        end
    endfunction

    initial load_defaults();

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            load_defaults();
            points_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (points_due.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("[%0t] result %0d arrived with nothing expected: %h",
                                 $time, result_no, i_out_data);
                end else begin
                    want = points_due.pop_front();
                    check_field("out_x", want.out_x, i_out_data.out_x);
                    check_field("out_y", want.out_y, i_out_data.out_y);
                    check_field("out_z", want.out_z, i_out_data.out_z);
                    check_field("step_index", want.step_index, i_out_data.step_index);
                    check_field("limit_reached", want.limit_reached,
                                i_out_data.limit_reached);
                    check_field("saturated", want.saturated, i_out_data.saturated);
                end
                result_no++;
            end
            if (i_cfg_we)
                write_setting(i_cfg_idx, i_cfg_data);
            if (i_in_valid && !i_in_stall)
                points_due.push_back(next_point(i_in_data));
        end
        o_pending <= points_due.size();
        o_errors  <= err_count;
    end

endmodule

/* verif/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import les_pkg::*;

    // q10.22 helpers
    localparam int FRAC = 22;
    localparam int ONE  = 1 << FRAC;

    localparam logic [31:0] S_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN     = 32'h8000_0000;
    localparam logic [31:0] DT_TOP    = 32'h003F_FFFF;
    localparam logic [31:0] LIMIT_TOP = 32'h00FF_FFFF;
    localparam logic [31:0] BETA_DEF  = (8 * ONE + 1) / 3;
    localparam logic [31:0] DT_DEF    = ONE / 100;
    localparam logic [31:0] LIMIT_DEF = 10000000;

    localparam int NUM_REGS = int'(CFG_LIMIT) + 1;
    // first register index past the list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX = CFG_IDX_W'(int'(CFG_LIMIT) + 1);

    localparam int TOTAL_ITEMS = 950;
    localparam int HOLD_CYCLES = 300;   // long output hold-off
    localparam int QUIET       = 16;    // step latency plus margin
    localparam int STALL_LIMIT = 2000;  // cycles with no handshake at all

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COORD_W-1:0]   i_cfg_data;

    int errors;
    int outstanding;

    logic [31:0] reg_val [NUM_REGS];
    int          items_sent = 0;
    int          burst_left = 0;
    bit          want_hold  = 1'b0;
    bit          holding    = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    lorenz_euler_step_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    les_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (outstanding)
    );

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coefficient or coordinate: mostly a sane range in whole units, sometimes extreme
    function automatic logic [31:0] pick_param(input int lo, input int hi);
        case ($urandom_range(0, 19))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return $urandom;
            default: return 32'(lo * ONE) + $urandom_range(0, (hi - lo) * ONE);
        endcase
    endfunction

    // upper bits of a raw random word are dropped by the block
    function automatic logic [31:0] pick_dt();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DT_TOP;
            2:       return $urandom;
            default: return $urandom_range(0, ONE / 50);
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return LIMIT_TOP;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    function automatic void fill_regs(input logic [31:0] sig, input logic [31:0] rh,
                                      input logic [31:0] bt, input logic [31:0] dt,
                                      input logic [31:0] ix, input logic [31:0] iy,
                                      input logic [31:0] iz, input logic [31:0] lim);
        reg_val[CFG_SIGMA]  = sig;
        reg_val[CFG_RHO]    = rh;
        reg_val[CFG_BETA]   = bt;
        reg_val[CFG_DT]     = dt;
        reg_val[CFG_INIT_X] = ix;
        reg_val[CFG_INIT_Y] = iy;
        reg_val[CFG_INIT_Z] = iz;
        reg_val[CFG_LIMIT]  = lim;
    endfunction

    function automatic void random_regs();
        if ($urandom_range(0, 3) == 0) begin
            // raw words everywhere, half the time with a reachable limit
            foreach (reg_val[k])
                reg_val[k] = $urandom;
            if ($urandom_range(0, 1) == 0)
                reg_val[CFG_LIMIT] = $urandom_range(1, 300);
        end else begin
            fill_regs(pick_param(5, 15), pick_param(10, 40), pick_param(1, 4), pick_dt(),
                      pick_param(-20, 20), pick_param(-20, 20), pick_param(0, 40),
                      pick_limit());
        end
    endfunction

    // one item, after a random gap; valid stays up after acceptance so that
    // back-to-back items need no extra edge
    task automatic send_item(input logic adv, input logic rs);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0)
                burst_left = $urandom_range(20, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{advance: adv, restart: rs};
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // stop offering and wait for every expected result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // registers change only with the block idle; one write per edge,
    // then a dropped write past the register list
    task automatic program_regs();
        drain();
        repeat (QUIET) @(posedge i_clk);
        for (int k = 0; k < NUM_REGS; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(k);
            i_cfg_data <= reg_val[k];
            @(posedge i_clk);
        end
        i_cfg_idx  <= CFG_IDX_W'(SPARE_IDX + $urandom_range(0, 7));
        i_cfg_data <= $urandom;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // output side stall: runs of readiness, then stalls of random length;
    // a requested hold-off takes the place of the next stall
    always begin : out_stall_gen
        int run_len;
        int hold_len;
        i_out_stall <= 1'b0;
        run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : 1 + pick_gap();
        repeat (run_len) @(posedge i_clk);
        if (want_hold) begin
            want_hold = 1'b0;
            hold_len  = HOLD_CYCLES;
            holding   = 1'b1;
        end else begin
            hold_len = pick_gap();
        end
        if (hold_len > 0) begin
            i_out_stall <= 1'b1;
            repeat (hold_len) @(posedge i_clk);
        end
        holding = 1'b0;
    end

    // timeout on a run that stops moving
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("lorenz_euler_step_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int phase_len;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: report only, restart only, plain steps, restart with step, report
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);

        // short limit: run into it, advance is then ignored, restart clears it
        fill_regs(10 * ONE, 28 * ONE, BETA_DEF, DT_DEF, ONE, 2 * ONE, 3 * ONE, 3);
        program_regs();
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);

        // zero limit counts as reached at once
        reg_val[CFG_LIMIT] = '0;
        program_regs();
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);

        // extreme coefficients and start points, largest step and none
        fill_regs(S_MAX, S_MIN, S_MAX, DT_TOP, S_MIN, S_MAX, S_MIN, LIMIT_TOP);
        program_regs();
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b0);
        fill_regs(S_MIN, S_MAX, S_MIN, '0, S_MAX, S_MAX, S_MAX, LIMIT_DEF);
        program_regs();
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);

        // random phases: fresh settings, mostly a restart and then a run of steps
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            random_regs();
            program_regs();
            phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                    : $urandom_range(30, 120);
            if ($urandom_range(0, 4) != 0)
                send_item(1'b1, 1'b1);
            for (int k = 0; k < phase_len && items_sent < TOTAL_ITEMS; k++) begin
                // hold the output back while items keep coming, so the block fills up
                if (k == 5 && phase % 4 == 0) begin
                    // the last item is taken, offer nothing while waiting
                    i_in_valid <= 1'b0;
                    want_hold = 1'b1;
                    wait (holding);
                    burst_left = 24;
                end
                send_item($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 5);
                // now and then let everything drain mid-phase
                if ($urandom_range(0, 79) == 0)
                    drain();
            end
            phase++;
        end

        drain();
        repeat (QUIET) @(posedge i_clk);
        if (errors == 0)
            $display("lorenz_euler_step_core: match");
        else
            $display("lorenz_euler_step_core: mismatch");
        $finish;
    end

endmodule
